### hdl/tcw_pkg.sv
package tcw_pkg;

	localparam int CMD_W  = 2;
	localparam int CHAR_W = 8;
	localparam int ADDR_W = 11;
	localparam int DATA_W = 16;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int TAB_W  = 4;
	localparam int UPC_W  = 5;

	localparam logic [CMD_W-1:0]  CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0]  CMD_CLEAR = 2'd2;
	localparam logic [CMD_W-1:0]  CMD_NOP   = 2'd3;

	localparam logic [CHAR_W-1:0] TAB_CODE     = 8'd9;
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
	localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h07;

	// Microprogram addresses
	localparam logic [UPC_W-1:0] ST_RST_FILL = 5'd0;
	localparam logic [UPC_W-1:0] ST_RST_DONE = 5'd1;
	localparam logic [UPC_W-1:0] ST_PUT      = 5'd2;
	localparam logic [UPC_W-1:0] ST_PUT_WR   = 5'd3;
	localparam logic [UPC_W-1:0] ST_EMIT     = 5'd4;
	localparam logic [UPC_W-1:0] ST_IDLE     = 5'd5;
	localparam logic [UPC_W-1:0] ST_D_READ   = 5'd6;
	localparam logic [UPC_W-1:0] ST_D_CLEAR  = 5'd7;
	localparam logic [UPC_W-1:0] ST_D_NOP    = 5'd8;
	localparam logic [UPC_W-1:0] ST_D_NL     = 5'd9;
	localparam logic [UPC_W-1:0] ST_NL0      = 5'd10;
	localparam logic [UPC_W-1:0] ST_NL1      = 5'd11;
	localparam logic [UPC_W-1:0] ST_READ0    = 5'd12;
	localparam logic [UPC_W-1:0] ST_READ1    = 5'd13;
	localparam logic [UPC_W-1:0] ST_CLR0     = 5'd14;
	localparam logic [UPC_W-1:0] ST_CLR1     = 5'd15;
	localparam logic [UPC_W-1:0] ST_CLR2     = 5'd16;
	localparam logic [UPC_W-1:0] ST_NR0      = 5'd17;
	localparam logic [UPC_W-1:0] ST_SCR0     = 5'd18;
	localparam logic [UPC_W-1:0] ST_SCR1     = 5'd19;
	localparam logic [UPC_W-1:0] ST_SCR2     = 5'd20;
	localparam logic [UPC_W-1:0] ST_SCR3     = 5'd21;
	localparam logic [UPC_W-1:0] ST_SCR4     = 5'd22;
	localparam logic [UPC_W-1:0] ST_LAST     = ST_SCR4;

	typedef enum logic [2:0] {
		M_NONE,
		M_FILL_RST,
		M_FILL_CFG,
		M_COPY,
		M_WRITE,
		M_READ
	} mem_op_t;

	typedef enum logic [2:0] {
		CU_NONE,
		CU_NEWROW,
		CU_ADVANCE,
		CU_HOME,
		CU_TAB_RESET
	} cur_op_t;

	typedef enum logic [3:0] {
		CND_NEVER,
		CND_ALWAYS,
		CND_NOREQ,
		CND_CMD_READ,
		CND_CMD_CLEAR,
		CND_CMD_NOP,
		CND_NOT_NL,
		CND_COL_FULL,
		CND_REP_MORE,
		CND_OUT_BUSY,
		CND_NOT_LAST,
		CND_PTR_MORE,
		CND_COPY_MORE
	} cond_t;

	typedef struct packed {
		logic             accept;
		logic             emit;
		logic             link;
		logic             ret;
		logic             ptr_clr;
		logic             set_sc;
		logic             capture;
		mem_op_t          mem_op;
		cur_op_t          cur_op;
		cond_t            cond;
		logic [UPC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic             no_req;
		logic [CMD_W-1:0] cmd;
		logic             char_nl;
		logic             col_full;
		logic             last_row;
		logic             ptr_more;
		logic             copy_more;
		logic             rep_more;
		logic             out_busy;
	} stat_t;

	localparam ctrl_t CTRL_NOP = '{
		accept:  1'b0,
		emit:    1'b0,
		link:    1'b0,
		ret:     1'b0,
		ptr_clr: 1'b0,
		set_sc:  1'b0,
		capture: 1'b0,
		mem_op:  M_NONE,
		cur_op:  CU_NONE,
		cond:    CND_NEVER,
		target:  ST_IDLE
	};

	function automatic ctrl_t urom(input logic [UPC_W-1:0] addr);
		ctrl_t w;
		w = CTRL_NOP;
		unique case (addr)
			ST_RST_FILL: begin
				w.mem_op = M_FILL_RST;
				w.cond   = CND_PTR_MORE;
				w.target = ST_RST_FILL;
			end
			ST_RST_DONE: begin
				w.cond   = CND_ALWAYS;
				w.target = ST_IDLE;
			end
			ST_PUT: begin
				w.cond   = CND_COL_FULL;
				w.link   = 1'b1;
				w.target = ST_NR0;
			end
			ST_PUT_WR: begin
				w.mem_op = M_WRITE;
				w.cur_op = CU_ADVANCE;
				w.cond   = CND_REP_MORE;
				w.target = ST_PUT;
			end
			ST_EMIT: begin
				w.emit   = 1'b1;
				w.cond   = CND_OUT_BUSY;
				w.target = ST_EMIT;
			end
			ST_IDLE: begin
				w.accept = 1'b1;
				w.cond   = CND_NOREQ;
				w.target = ST_IDLE;
			end
			ST_D_READ: begin
				w.cond   = CND_CMD_READ;
				w.target = ST_READ0;
			end
			ST_D_CLEAR: begin
				w.cond   = CND_CMD_CLEAR;
				w.target = ST_CLR0;
			end
			ST_D_NOP: begin
				w.cond   = CND_CMD_NOP;
				w.target = ST_EMIT;
			end
			ST_D_NL: begin
				w.cond   = CND_NOT_NL;
				w.target = ST_PUT;
			end
			ST_NL0: begin
				w.cond   = CND_ALWAYS;
				w.link   = 1'b1;
				w.target = ST_NR0;
			end
			ST_NL1: begin
				w.cur_op = CU_TAB_RESET;
				w.cond   = CND_ALWAYS;
				w.target = ST_EMIT;
			end
			ST_READ0: begin
				w.mem_op = M_READ;
			end
			ST_READ1: begin
				w.capture = 1'b1;
				w.cond    = CND_ALWAYS;
				w.target  = ST_EMIT;
			end
			ST_CLR0: begin
				w.ptr_clr = 1'b1;
			end
			ST_CLR1: begin
				w.mem_op = M_FILL_CFG;
				w.cond   = CND_PTR_MORE;
				w.target = ST_CLR1;
			end
			ST_CLR2: begin
				w.cur_op = CU_HOME;
				w.cond   = CND_ALWAYS;
				w.target = ST_EMIT;
			end
			ST_NR0: begin
				w.cur_op = CU_NEWROW;
				w.cond   = CND_NOT_LAST;
				w.ret    = 1'b1;
			end
			ST_SCR0: begin
				w.ptr_clr = 1'b1;
				w.set_sc  = 1'b1;
			end
			ST_SCR1: begin
				w.mem_op = M_COPY;
				w.cond   = CND_COPY_MORE;
				w.target = ST_SCR1;
			end
			ST_SCR2: begin
				w.mem_op = M_NONE;
			end
			ST_SCR3: begin
				w.mem_op = M_FILL_CFG;
				w.cond   = CND_PTR_MORE;
				w.target = ST_SCR3;
			end
			ST_SCR4: begin
				w.cond = CND_ALWAYS;
				w.ret  = 1'b1;
			end
			default: begin
				w.cond   = CND_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

### hdl/tcw_ifs.sv
interface tcw_req_if import tcw_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [CHAR_W-1:0] char_code;
	logic [ADDR_W-1:0] cell_addr;

	modport source (output valid, cmd, char_code, cell_addr, input ready);
	modport sink (input valid, cmd, char_code, cell_addr, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*;;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] cell_data;
	logic [COL_W-1:0]  cursor_col;
	logic [ROW_W-1:0]  cursor_row;
	logic              scrolled;

	modport source (output valid, cell_data, cursor_col, cursor_row, scrolled, input ready);
	modport sink (input valid, cell_data, cursor_col, cursor_row, scrolled, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] text_color;

	modport source (output valid, text_color, input ready);
	modport sink (input valid, text_color, output ready);
endinterface

### hdl/tcw_useq.sv
module tcw_useq import tcw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] ret_q;
	logic [UPC_W-1:0] upc_inc;
	logic             take;

	assign ctrl    = urom(upc_q);
	assign upc_inc = upc_q + UPC_W'(1);

	always_comb begin
		unique case (ctrl.cond)
			CND_NEVER:     take = 1'b0;
			CND_ALWAYS:    take = 1'b1;
			CND_NOREQ:     take = stat.no_req;
			CND_CMD_READ:  take = (stat.cmd == CMD_READ);
			CND_CMD_CLEAR: take = (stat.cmd == CMD_CLEAR);
			CND_CMD_NOP:   take = (stat.cmd == CMD_NOP);
			CND_NOT_NL:    take = !stat.char_nl;
			CND_COL_FULL:  take = stat.col_full;
			CND_REP_MORE:  take = stat.rep_more;
			CND_OUT_BUSY:  take = stat.out_busy;
			CND_NOT_LAST:  take = !stat.last_row;
			CND_PTR_MORE:  take = stat.ptr_more;
			CND_COPY_MORE: take = stat.copy_more;
			default:       take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_RST_FILL;
			ret_q <= ST_IDLE;
		end else begin
			if (take) begin
				upc_q <= ctrl.ret ? ret_q : ctrl.target;
			end else begin
				upc_q <= upc_inc;
			end
			// save the return point on a taken call
			if (take && ctrl.link) begin
				ret_q <= upc_inc;
			end
		end
	end

	a_ret_point: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.ret && take) |-> (ret_q == ST_PUT_WR || ret_q == ST_NL1))
		else $error("return to a step that never calls");

	a_upc_range: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q <= ST_LAST)
		else $error("step counter left the program");

endmodule

### hdl/tcw_datapath.sv
module tcw_datapath import tcw_pkg::*; #(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  ctrl_t ctrl,
	output stat_t stat,
	tcw_req_if.sink   req,
	tcw_rsp_if.source rsp,
	tcw_cfg_if.sink   cfg
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int CELL_W = $clog2(CELLS);
	localparam int CMP_W  = (CELL_W > ADDR_W) ? CELL_W : ADDR_W;

	logic [DATA_W-1:0] screen_mem [CELLS];

	logic [CHAR_W-1:0] color_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [TAB_W-1:0]  tab_q;
	logic [TAB_W-1:0]  cnt_q;
	logic [CELL_W-1:0] ptr_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [CHAR_W-1:0] put_char_q;
	logic              nl_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] data_q;
	logic              sc_q;
	logic [DATA_W-1:0] rdata_q;
	logic              copy_vld_s1;
	logic [CELL_W-1:0] copy_addr_s1;

	logic              out_vld_q;
	logic [DATA_W-1:0] out_data_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic              out_sc_q;

	logic              take_req;
	logic              out_busy;
	logic              emit_fire;
	logic              rd_ok;
	logic              last_row;
	logic              sweep_step;
	logic [CELL_W-1:0] cur_idx;
	logic              we;
	logic [CELL_W-1:0] waddr;
	logic [DATA_W-1:0] wdata;
	logic [CELL_W-1:0] raddr;

	assign take_req   = ctrl.accept && req.valid;
	assign out_busy   = out_vld_q && !rsp.ready;
	assign emit_fire  = ctrl.emit && !out_busy;
	assign rd_ok      = CMP_W'(addr_q) < CMP_W'(CELLS);
	assign last_row   = (row_q == ROW_W'(ROWS - 1));
	assign cur_idx    = CELL_W'(row_q) * CELL_W'(COLUMNS) + CELL_W'(col_q);
	assign sweep_step = (ctrl.mem_op == M_FILL_RST) || (ctrl.mem_op == M_FILL_CFG)
		|| (ctrl.mem_op == M_COPY);

	assign req.ready = ctrl.accept;
	assign cfg.ready = 1'b1;

	assign rsp.valid      = out_vld_q;
	assign rsp.cell_data  = out_data_q;
	assign rsp.cursor_col = out_col_q;
	assign rsp.cursor_row = out_row_q;
	assign rsp.scrolled   = out_sc_q;

	assign stat.no_req    = !req.valid;
	assign stat.cmd       = cmd_q;
	assign stat.char_nl   = nl_q;
	assign stat.col_full  = (col_q >= COL_W'(COLUMNS));
	assign stat.last_row  = last_row;
	assign stat.ptr_more  = (ptr_q != CELL_W'(CELLS - 1));
	assign stat.copy_more = (ptr_q != CELL_W'(CELLS - COLUMNS - 1));
	assign stat.rep_more  = (cnt_q != TAB_W'(1));
	assign stat.out_busy  = out_busy;

	// single write port: a copy in flight writes back the row below
	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = {color_q, SPACE_CODE};
		priority if (copy_vld_s1) begin
			we    = 1'b1;
			waddr = copy_addr_s1;
			wdata = rdata_q;
		end else if (ctrl.mem_op == M_FILL_RST) begin
			we    = 1'b1;
			wdata = {RESET_COLOR, SPACE_CODE};
		end else if (ctrl.mem_op == M_FILL_CFG) begin
			we    = 1'b1;
		end else if (ctrl.mem_op == M_WRITE) begin
			we    = 1'b1;
			waddr = cur_idx;
			wdata = {color_q, put_char_q};
		end else begin
			we    = 1'b0;
		end
	end

	always_comb begin
		priority if (ctrl.mem_op == M_COPY) begin
			raddr = ptr_q + CELL_W'(COLUMNS);
		end else if (rd_ok) begin
			raddr = CELL_W'(addr_q);
		end else begin
			raddr = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			screen_mem[waddr] <= wdata;
		end
		rdata_q <= screen_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q     <= RESET_COLOR;
			col_q       <= '0;
			row_q       <= '0;
			tab_q       <= TAB_W'(TAB_WIDTH);
			ptr_q       <= '0;
			copy_vld_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				color_q <= cfg.text_color;
			end

			if (ctrl.ptr_clr) begin
				ptr_q <= '0;
			end else if (sweep_step) begin
				ptr_q <= ptr_q + CELL_W'(1);
			end
			copy_vld_s1 <= (ctrl.mem_op == M_COPY);

			unique case (ctrl.cur_op)
				CU_NEWROW: begin
					col_q <= '0;
					if (!last_row) begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				CU_ADVANCE: begin
					col_q <= col_q + COL_W'(1);
					if (tab_q <= TAB_W'(1)) begin
						tab_q <= TAB_W'(TAB_WIDTH);
					end else begin
						tab_q <= tab_q - TAB_W'(1);
					end
				end
				CU_HOME: begin
					col_q <= '0;
					row_q <= '0;
					tab_q <= TAB_W'(TAB_WIDTH);
				end
				CU_TAB_RESET: begin
					tab_q <= TAB_W'(TAB_WIDTH);
				end
				default: begin
				end
			endcase

			if (emit_fire) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			cmd_q      <= req.cmd;
			addr_q     <= req.cell_addr;
			nl_q       <= (req.char_code == NEWLINE_CODE);
			// a tab prints spaces up to the next stop
			put_char_q <= (req.char_code == TAB_CODE) ? SPACE_CODE : req.char_code;
			cnt_q      <= (req.char_code == TAB_CODE) ? tab_q : TAB_W'(1);
			sc_q       <= 1'b0;
			data_q     <= '0;
		end else begin
			if (ctrl.cur_op == CU_ADVANCE) begin
				cnt_q <= cnt_q - TAB_W'(1);
			end
			if (ctrl.set_sc) begin
				sc_q <= 1'b1;
			end
			if (ctrl.capture) begin
				data_q <= rd_ok ? rdata_q : '0;
			end
		end
		copy_addr_s1 <= ptr_q;
		if (emit_fire) begin
			out_data_q <= data_q;
			out_col_q  <= col_q;
			out_row_q  <= row_q;
			out_sc_q   <= sc_q;
		end
	end

	a_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		copy_vld_s1 |-> !(ctrl.mem_op == M_WRITE || ctrl.mem_op == M_FILL_RST
			|| ctrl.mem_op == M_FILL_CFG))
		else $error("write port claimed twice");

	a_put_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.mem_op == M_WRITE) |-> (col_q < COL_W'(COLUMNS) && row_q < ROW_W'(ROWS)))
		else $error("character write outside the screen");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q < ROW_W'(ROWS))
		else $error("cursor row past the last row");

endmodule

### hdl/text_console_char_writer_unit.sv
// Requests are served one at a time; the next can be taken, at the earliest, in the cycle
// after the result is registered. A scroll sweeps the screen store one cell per cycle
// (one write port and one read port), and so does a clear. After arst_n the store is
// swept to blank cells with req.ready low.
module text_console_char_writer_unit import tcw_pkg::*; #(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	tcw_req_if.sink   req,
	tcw_rsp_if.source rsp,
	tcw_cfg_if.sink   cfg
);

	ctrl_t ctrl;
	stat_t stat;

	tcw_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	tcw_datapath #(
		.COLUMNS   (COLUMNS),
		.ROWS      (ROWS),
		.TAB_WIDTH (TAB_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench import tcw_pkg::*;;

	localparam int COLUMNS         = 80;
	localparam int ROWS            = 25;
	localparam int TAB_WIDTH       = 8;
	localparam int CELL_TOTAL      = COLUMNS * ROWS;
	localparam int PHASE_ITEMS     = 255;
	localparam int PHASE_COUNT     = 6;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int REPORT_LIMIT    = 10;

	localparam logic [CMD_W-1:0] CMD_PUT = 2'd0;

	typedef struct {
		logic [DATA_W-1:0] cell_data;
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic              scrolled;
	} console_result_t;

	class console_scoreboard;
		logic [DATA_W-1:0] cells [CELL_TOTAL];
		int unsigned       col;
		int unsigned       row;
		int unsigned       tab_left;
		logic [CHAR_W-1:0] color;
		console_result_t   awaited [$];
		int                mismatches;
		int                checked;
		int                reads;
		int                clears;
		int                scrolls;

		function new();
			color = RESET_COLOR;
			col = 0;
			row = 0;
			tab_left = TAB_WIDTH;
			blank_screen();
		endfunction

		function void blank_screen();
			foreach (cells[i])
				cells[i] = {color, SPACE_CODE};
		endfunction

		function void scroll_screen();
			for (int i = 0; i < CELL_TOTAL; i++)
				cells[i] = (i + COLUMNS < CELL_TOTAL) ? cells[i + COLUMNS] : {color, SPACE_CODE};
			if (row > 0)
				row--;
		endfunction

		function bit next_line();
			col = 0;
			row++;
			if (row >= ROWS) begin
				row = ROWS;
				scroll_screen();
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function bit put_char(logic [CHAR_W-1:0] ch);
			bit sc;
			int unsigned idx;
			sc = 1'b0;
			// resolve a pending wrap before the write
			if (col >= COLUMNS)
				sc = next_line();
			idx = row * COLUMNS + col;
			if (idx < CELL_TOTAL)
				cells[idx] = {color, ch};
			col++;
			if (tab_left <= 1)
				tab_left = TAB_WIDTH;
			else
				tab_left--;
			return sc;
		endfunction

		function void note_request(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
				logic [ADDR_W-1:0] addr);
			console_result_t want;
			int unsigned spaces;
			bit sc;
			want.cell_data = '0;
			sc = 1'b0;
			case (cmd)
				CMD_PUT: begin
					if (ch == TAB_CODE) begin
						spaces = tab_left;
						for (int j = 0; j < spaces; j++)
							if (put_char(SPACE_CODE))
								sc = 1'b1;
						tab_left = TAB_WIDTH;
					end else if (ch == NEWLINE_CODE) begin
						sc = next_line();
						tab_left = TAB_WIDTH;
					end else begin
						sc = put_char(ch);
					end
				end
				CMD_READ: begin
					reads++;
					if (addr < CELL_TOTAL)
						want.cell_data = cells[addr];
				end
				CMD_CLEAR: begin
					clears++;
					blank_screen();
					col = 0;
					row = 0;
					tab_left = TAB_WIDTH;
				end
				CMD_NOP: ;
			endcase
			if (sc)
				scrolls++;
			want.cursor_col = COL_W'(col);
			want.cursor_row = ROW_W'(row);
			want.scrolled = sc;
			awaited.push_back(want);
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("MISMATCH at %0t: %s", $realtime, msg);
		endfunction

		function void check_result(console_result_t got);
			console_result_t want;
			if (awaited.size() == 0) begin
				flag($sformatf("result with nothing pending: data=%h col=%0d row=%0d scrolled=%b",
					got.cell_data, got.cursor_col, got.cursor_row, got.scrolled));
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (got.cell_data !== want.cell_data || got.cursor_col !== want.cursor_col ||
					got.cursor_row !== want.cursor_row || got.scrolled !== want.scrolled)
				flag($sformatf({"result %0d: expected data=%h col=%0d row=%0d scrolled=%b,",
					" got data=%h col=%0d row=%0d scrolled=%b"}, checked,
					want.cell_data, want.cursor_col, want.cursor_row, want.scrolled,
					got.cell_data, got.cursor_col, got.cursor_row, got.scrolled));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   idling_on = 1'b1;
	bit   hold_off_request = 1'b0;
	int   requests_sent = 0;
	int   color_writes = 0;

	console_scoreboard board = new();

	tcw_req_if req ();
	tcw_rsp_if rsp ();
	tcw_cfg_if cfg ();

	text_console_char_writer_unit #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_WIDTH(TAB_WIDTH)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin : sample_handshakes
		console_result_t got;
		if (cfg.valid && cfg.ready) begin
			board.color = cfg.text_color;
			color_writes++;
		end
		if (req.valid && req.ready)
			board.note_request(req.cmd, req.char_code, req.cell_addr);
		if (rsp.valid && rsp.ready) begin
			got.cell_data = rsp.cell_data;
			got.cursor_col = rsp.cursor_col;
			got.cursor_row = rsp.cursor_row;
			got.scrolled = rsp.scrolled;
			board.check_result(got);
		end
	end

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				stall_left = HOLD_OFF_CYCLES;
			end else if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 13);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Watchdog: nothing moved for %0d cycles, %0d results outstanding",
			quiet, board.awaited.size());
		$display("*** FAILED ***");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after acceptance with
	// valid still high, so the next request replaces it or wait_drained drops it.
	task automatic send_request(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
			logic [ADDR_W-1:0] addr);
		if (idling_on && $urandom_range(0, 9) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= cmd;
		req.char_code <= ch;
		req.cell_addr <= addr;
		do
			@(posedge clk);
		while (!req.ready);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic write_color(logic [CHAR_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.text_color <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (board.awaited.size() != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		logic [CHAR_W-1:0] palette [PHASE_COUNT];
		logic [CHAR_W-1:0] ch;
		logic [ADDR_W-1:0] addr;
		int                kind;
		int                len;
		int                phase_end;
		int                pick;

		req.valid = 1'b0;
		req.cmd = CMD_PUT;
		req.char_code = '0;
		req.cell_addr = '0;
		cfg.valid = 1'b0;
		cfg.text_color = '0;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset contents, reads past the store, unused command
		send_request(CMD_READ, 8'h00, 11'd0);
		send_request(CMD_READ, 8'hFF, 11'd1999);
		send_request(CMD_READ, 8'h00, 11'd2000);
		send_request(CMD_READ, 8'hFF, 11'h7FF);
		send_request(CMD_NOP, 8'hA5, 11'h2AA);
		wait_drained();
		write_color(8'h00);
		send_request(CMD_PUT, 8'h00, 11'h7FF);
		send_request(CMD_PUT, 8'hFF, 11'h000);
		send_request(CMD_PUT, TAB_CODE, 11'h555);
		send_request(CMD_PUT, NEWLINE_CODE, 11'h0);
		// fill a whole row with tabs to leave a wrap pending, then wrap
		repeat (COLUMNS / TAB_WIDTH) send_request(CMD_PUT, TAB_CODE, 11'h0);
		send_request(CMD_PUT, 8'h41, 11'h0);
		send_request(CMD_READ, 8'h00, 11'd1);
		send_request(CMD_READ, 8'h00, 11'd160);
		send_request(CMD_CLEAR, NEWLINE_CODE, 11'd5);
		send_request(CMD_READ, 8'h00, 11'd1);
		wait_drained();

		palette[0] = 8'hFF;
		palette[1] = 8'h00;
		palette[2] = CHAR_W'($urandom_range(0, 255));
		palette[3] = 8'h80;
		palette[4] = 8'h7F;
		palette[5] = CHAR_W'($urandom_range(0, 255));

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			write_color(palette[phase]);
			if (phase == 2)
				hold_off_request = 1'b1;
			if (phase == PHASE_COUNT - 1)
				idling_on = 1'b0;
			phase_end = requests_sent + PHASE_ITEMS;
			// start each phase with a run of newlines so the bottom row is reached early
			len = $urandom_range(ROWS, ROWS + 4);
			repeat (len)
				send_request(CMD_PUT, NEWLINE_CODE, ADDR_W'($urandom_range(0, 2047)));
			while (requests_sent < phase_end) begin
				kind = $urandom_range(0, 99);
				if (kind < 48) begin
					len = $urandom_range(1, 24);
					repeat (len) begin
						pick = $urandom_range(0, 15);
						if (pick == 0)
							ch = TAB_CODE;
						else if (pick == 1)
							ch = NEWLINE_CODE;
						else
							ch = CHAR_W'($urandom_range(0, 255));
						send_request(CMD_PUT, ch, ADDR_W'($urandom_range(0, 2047)));
					end
				end else if (kind < 60) begin
					len = $urandom_range(1, 6);
					repeat (len)
						send_request(CMD_PUT, NEWLINE_CODE, ADDR_W'($urandom_range(0, 2047)));
				end else if (kind < 85) begin
					len = $urandom_range(1, 8);
					repeat (len) begin
						pick = $urandom_range(0, 9);
						// favor the current row, where the latest text sits
						if (pick < 5)
							addr = ADDR_W'(board.row * COLUMNS + $urandom_range(0, COLUMNS - 1));
						else if (pick < 9)
							addr = ADDR_W'($urandom_range(0, CELL_TOTAL - 1));
						else
							addr = ADDR_W'($urandom_range(CELL_TOTAL, 2047));
						send_request(CMD_READ, CHAR_W'($urandom_range(0, 255)), addr);
					end
				end else if (kind < 95) begin
					len = $urandom_range(1, 3);
					repeat (len)
						send_request(CMD_NOP, CHAR_W'($urandom_range(0, 255)),
							ADDR_W'($urandom_range(0, 2047)));
				end else begin
					send_request(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
						ADDR_W'($urandom_range(0, 2047)));
				end
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Run covered %0d requests (%0d cell reads, %0d clears, %0d that scrolled)",
			requests_sent, board.reads, board.clears, board.scrolls);
		$display("over %0d text color settings; %0d results checked, %0d mismatches",
			color_writes, board.checked, board.mismatches);
		if (board.awaited.size() != 0)
			$display("%0d expected results never arrived", board.awaited.size());
		if (board.mismatches == 0 && board.awaited.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
